/* hw/rtl/sieve_nth_prime_top_assert.svh */
// ----------------------------------------------------------------------------
// sieve_nth_prime_top_assert.svh - assertion macros
// Short forms for the concurrent checks of the sieve block. Each macro
// samples on clk and is disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef SIEVE_NTH_PRIME_TOP_ASSERT_SVH
`define SIEVE_NTH_PRIME_TOP_ASSERT_SVH

// Same-cycle implication.
`define SNP_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sieve_nth_prime check failed");

// Next-cycle implication.
`define SNP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sieve_nth_prime check failed");

`endif

/* hw/rtl/snp_pkg.sv */
// ----------------------------------------------------------------------------
// snp_pkg - shared constants of the N-th prime lookup block
// Field widths and the default size of the composite map.
// ----------------------------------------------------------------------------
package snp_pkg;

	// Default number of entries in the composite map.
	localparam int SIEVE_SIZE_DEFAULT = 65536;

	// Width of the query index field.
	localparam int INDEX_W = 16;

	// Width of the returned prime.
	localparam int VALUE_W = 16;

endpackage

/* hw/rtl/sieve_nth_prime_top.sv */
// ----------------------------------------------------------------------------
// sieve_nth_prime_top - N-th prime lookup
// After reset the block holds busy high while it builds a one-bit-per-number
// composite map of SIEVE_SIZE entries: a clearing pass, then the sieve
// itself, which tests each base below the square root of SIEVE_SIZE and
// marks the multiples of each prime base from its square upward. A query
// transaction is taken when start is high and busy is low. Index zero
// answers in the next cycle; any other index is answered by a scan that
// reads one map entry per cycle through the map's single read port, up to
// the N-th prime or the end of the map. The result is shown for exactly
// one cycle with done high and cannot be stalled; the next query may start
// in that same cycle.
// ----------------------------------------------------------------------------
module sieve_nth_prime_top
	import snp_pkg::*;
#(
	parameter int SIEVE_SIZE = SIEVE_SIZE_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [INDEX_W-1:0] prime_index,
	output logic               done,
	output logic [VALUE_W-1:0] prime_value,
	output logic               not_found
);

	`include "sieve_nth_prime_top_assert.svh"

	localparam int AW = $clog2(SIEVE_SIZE);

	logic          sieve_done;
	logic          scan_busy;
	logic          accept;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic          wr_data;
	logic [AW-1:0] sieve_rd_addr;
	logic [AW-1:0] scan_rd_addr;
	logic [AW-1:0] rd_addr;
	logic          rd_data;

	// Composite map.
	snp_ram #(
		.WIDTH(1),
		.DEPTH(SIEVE_SIZE)
	) u_map (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// Map builder.
	snp_sieve #(
		.SIEVE_SIZE(SIEVE_SIZE)
	) u_sieve (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_data   (rd_data),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_addr   (sieve_rd_addr),
		.sieve_done(sieve_done)
	);

	// Query scanner.
	snp_scan #(
		.SIEVE_SIZE(SIEVE_SIZE)
	) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.prime_index(prime_index),
		.rd_data    (rd_data),
		.rd_addr    (scan_rd_addr),
		.scan_busy  (scan_busy),
		.done       (done),
		.prime_value(prime_value),
		.not_found  (not_found)
	);

	// The read port belongs to the sieve until the map is finished.
	assign rd_addr = sieve_done ? scan_rd_addr : sieve_rd_addr;
	assign busy    = !sieve_done || scan_busy;
	assign accept  = start && !busy;

	`SNP_ASSERT_NEXT(a_done_sticky, sieve_done, sieve_done)
	`SNP_ASSERT_NOW(a_result_after_sieve, done, sieve_done)
	`SNP_ASSERT_NOW(a_miss_zero, done && not_found, prime_value == '0)
	`SNP_ASSERT_NOW(a_found_prime, done && !not_found, prime_value >= VALUE_W'(2))
	`SNP_ASSERT_NEXT(a_query_busy, accept && (prime_index != '0), busy && !done)

endmodule

/* hw/rtl/snp_ram.sv */
// ----------------------------------------------------------------------------
// snp_ram - generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module snp_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

/* hw/rtl/snp_sieve.sv */
// ----------------------------------------------------------------------------
// snp_sieve - builds the composite map after reset
// Clears the map one entry a cycle (marking 0 and 1), then runs the Sieve
// of Eratosthenes with one adder stepping through multiples.
// ----------------------------------------------------------------------------
module snp_sieve
	import snp_pkg::*;
#(
	parameter int SIEVE_SIZE = SIEVE_SIZE_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          rd_data,
	output logic                          wr_en,
	output logic [$clog2(SIEVE_SIZE)-1:0] wr_addr,
	output logic                          wr_data,
	output logic [$clog2(SIEVE_SIZE)-1:0] rd_addr,
	output logic                          sieve_done
);

	localparam int AW = $clog2(SIEVE_SIZE);
	localparam logic [AW-1:0] LAST_ADDR = AW'(SIEVE_SIZE - 1);
	localparam logic [AW:0]   SIZE_W    = (AW + 1)'(SIEVE_SIZE);

	typedef enum logic [2:0] {
		SV_CLEAR,
		SV_PREAD,
		SV_PTEST,
		SV_MARK,
		SV_DONE
	} sieve_state_t;

	sieve_state_t state_q;
	logic [AW-1:0] clr_q;
	logic [AW-1:0] p_q;
	logic [AW:0]   sq_q;
	logic [AW:0]   m_q;
	logic [AW:0]   m_next;
	logic [AW:0]   sq_next;

	// Next multiple and next square ((p+1)^2 = p^2 + 2p + 1).
	assign m_next  = m_q + {1'b0, p_q};
	assign sq_next = sq_q + {p_q, 1'b1};

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SV_CLEAR;
			clr_q   <= '0;
			p_q     <= AW'(2);
			sq_q    <= (AW + 1)'(4);
			m_q     <= '0;
		end else begin
			case (state_q)
				SV_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST_ADDR) begin
						state_q <= SV_PREAD;
					end
				end
				SV_PREAD: begin
					if (sq_q >= SIZE_W) begin
						state_q <= SV_DONE;
					end else begin
						state_q <= SV_PTEST;
					end
				end
				SV_PTEST: begin
					if (!rd_data) begin
						m_q     <= sq_q;
						state_q <= SV_MARK;
					end else begin
						p_q     <= p_q + 1'b1;
						sq_q    <= sq_next;
						state_q <= SV_PREAD;
					end
				end
				SV_MARK: begin
					if (m_next >= SIZE_W) begin
						p_q     <= p_q + 1'b1;
						sq_q    <= sq_next;
						state_q <= SV_PREAD;
					end else begin
						m_q <= m_next;
					end
				end
				SV_DONE: begin
					state_q <= SV_DONE;
				end
				default: begin
					state_q <= SV_CLEAR;
				end
			endcase
		end
	end

	// Map write port: clearing pass, then marking of multiples.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = clr_q;
		wr_data = 1'b0;
		case (state_q)
			SV_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
				wr_data = (clr_q < AW'(2));
			end
			SV_MARK: begin
				wr_en   = 1'b1;
				wr_addr = m_q[AW-1:0];
				wr_data = 1'b1;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	assign rd_addr    = p_q;
	assign sieve_done = (state_q == SV_DONE);

endmodule

/* hw/rtl/snp_scan.sv */
// ----------------------------------------------------------------------------
// snp_scan - answers one query by scanning the composite map
// Reads one map entry a cycle from 0 upward, counts unmarked entries and
// stops at the N-th one or at the end of the map.
// ----------------------------------------------------------------------------
module snp_scan
	import snp_pkg::*;
#(
	parameter int SIEVE_SIZE = SIEVE_SIZE_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic [INDEX_W-1:0]            prime_index,
	input  logic                          rd_data,
	output logic [$clog2(SIEVE_SIZE)-1:0] rd_addr,
	output logic                          scan_busy,
	output logic                          done,
	output logic [VALUE_W-1:0]            prime_value,
	output logic                          not_found
);

	localparam int AW = $clog2(SIEVE_SIZE);
	localparam logic [AW-1:0] LAST_ADDR = AW'(SIEVE_SIZE - 1);

	typedef enum logic {
		SC_IDLE,
		SC_RUN
	} scan_state_t;

	scan_state_t state_q;
	logic               issue_q;
	logic [AW-1:0]      k_q;
	logic               vld_s1;
	logic [AW-1:0]      k_s1;
	logic [INDEX_W-1:0] want_q;
	logic [INDEX_W-1:0] seen_q;
	logic [INDEX_W-1:0] seen_inc;
	logic               done_q;
	logic [VALUE_W-1:0] value_q;
	logic               miss_q;
	logic               hit;
	logic               fits;

	assign seen_inc = seen_q + INDEX_W'(1);
	assign hit      = vld_s1 && !rd_data && (seen_inc == want_q);
	assign fits     = ((k_s1 >> VALUE_W) == '0);

	// Scan sequencer with one read stage in flight.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SC_IDLE;
			issue_q <= 1'b0;
			vld_s1  <= 1'b0;
			done_q  <= 1'b0;
			miss_q  <= 1'b0;
			k_q     <= '0;
			k_s1    <= '0;
			want_q  <= '0;
			seen_q  <= '0;
			value_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				SC_IDLE: begin
					vld_s1 <= 1'b0;
					if (accept) begin
						if (prime_index == '0) begin
							done_q  <= 1'b1;
							value_q <= '0;
							miss_q  <= 1'b1;
						end else begin
							want_q  <= prime_index;
							seen_q  <= '0;
							k_q     <= '0;
							issue_q <= 1'b1;
							state_q <= SC_RUN;
						end
					end
				end
				SC_RUN: begin
					// Issue the next read.
					vld_s1 <= issue_q;
					k_s1   <= k_q;
					if (issue_q) begin
						k_q <= k_q + 1'b1;
						if (k_q == LAST_ADDR) begin
							issue_q <= 1'b0;
						end
					end
					// Check the entry read in the previous cycle.
					if (hit) begin
						done_q  <= 1'b1;
						value_q <= fits ? VALUE_W'(k_s1) : '0;
						miss_q  <= !fits;
						issue_q <= 1'b0;
						vld_s1  <= 1'b0;
						state_q <= SC_IDLE;
					end else if (vld_s1 && (k_s1 == LAST_ADDR)) begin
						done_q  <= 1'b1;
						value_q <= '0;
						miss_q  <= 1'b1;
						issue_q <= 1'b0;
						vld_s1  <= 1'b0;
						state_q <= SC_IDLE;
					end else if (vld_s1 && !rd_data) begin
						seen_q <= seen_inc;
					end
				end
				default: begin
					state_q <= SC_IDLE;
				end
			endcase
		end
	end

	assign rd_addr     = k_q;
	assign scan_busy   = (state_q == SC_RUN);
	assign done        = done_q;
	assign prime_value = value_q;
	assign not_found   = miss_q;

endmodule

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top - testbench of the N-th prime lookup block
// Builds its own table of primes below SIEVE_SIZE, sends a directed set of
// query transactions (index zero, the first primes, the last prime in the map
// and indexes past it) and then random ones, most with small indexes. Each
// result is checked field by field against the table in order of issue.
// ----------------------------------------------------------------------------
module tb_top;
	import snp_pkg::*;

	localparam int SIEVE_SIZE = SIEVE_SIZE_DEFAULT;
	localparam int RANDOM_QUERIES = 100;
	localparam int TAIL_CYCLES = 16;
	// Sender idle percentage per random phase. The third phase would stall the
	// receiver, but results cannot be held off, so it runs without gaps.
	localparam int GAP_PCT [4] = '{0, 50, 0, 7};

	typedef struct {
		logic [INDEX_W-1:0] index;
		int                 gap_pct;
	} pending_query_t;

	typedef struct {
		logic [INDEX_W-1:0] index;
		logic [VALUE_W-1:0] value;
		logic               missing;
	} prime_answer_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic [INDEX_W-1:0] prime_index = '0;
	logic               busy;
	logic               done;
	logic [VALUE_W-1:0] prime_value;
	logic               not_found;

	bit             is_composite [SIEVE_SIZE];
	int             prime_table [$];
	pending_query_t query_q [$];
	prime_answer_t  answer_q [$];

	int    issued_count = 0;
	int    accepted_count = 0;
	int    answered_count = 0;
	int    found_count = 0;
	int    missing_count = 0;
	int    error_count = 0;
	longint cycle_count = 0;
	longint cycle_limit = 0;

	sieve_nth_prime_top #(
		.SIEVE_SIZE(SIEVE_SIZE)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.prime_index(prime_index),
		.done(done),
		.prime_value(prime_value),
		.not_found(not_found)
	);

	// Free-running clock.
	initial begin
		forever #5 clk = ~clk;
	end

	// Sieve of Eratosthenes over the same range as the block's map.
	task automatic build_prime_table();
		longint p;
		longint m;
		for (int k = 0; k < SIEVE_SIZE; k++) is_composite[k] = 1'b0;
		is_composite[0] = 1'b1;
		is_composite[1] = 1'b1;
		for (p = 2; p * p < SIEVE_SIZE; p++) begin
			if (!is_composite[p]) begin
				for (m = p * p; m < SIEVE_SIZE; m += p) is_composite[m] = 1'b1;
			end
		end
		for (int k = 0; k < SIEVE_SIZE; k++) begin
			if (!is_composite[k]) prime_table.push_back(k);
		end
	endtask

	// Expected answer for one index: the N-th prime, or not found when the
	// index is zero, runs past the table, or the prime does not fit the port.
	function automatic prime_answer_t predict_answer(input logic [INDEX_W-1:0] n);
		prime_answer_t a;
		int            pos;
		a.index = n;
		a.value = '0;
		a.missing = 1'b1;
		pos = int'(n);
		if (pos != 0 && pos <= prime_table.size()) begin
			if (prime_table[pos-1] < (1 << VALUE_W)) begin
				a.value = prime_table[pos-1][VALUE_W-1:0];
				a.missing = 1'b0;
			end
		end
		return a;
	endfunction

	// Queue a query and add its worst scan time to the run limit.
	task automatic add_query(input logic [INDEX_W-1:0] n, input int gap_pct);
		prime_answer_t a;
		pending_query_t q;
		a = predict_answer(n);
		q.index = n;
		q.gap_pct = gap_pct;
		query_q.push_back(q);
		if (n == 0) cycle_limit += 2;
		else if (a.missing) cycle_limit += SIEVE_SIZE + 3;
		else cycle_limit += int'(a.value) + 3;
		cycle_limit += 20;
	endtask

	task automatic report_mismatch(input string msg);
		error_count++;
		$display("[%0t] MISMATCH: %s", $realtime, msg);
	endtask

	// Driver: a query is held until busy drops, then the next one is chosen.
	always @(negedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
			prime_index <= '0;
		end else if (start && accepted_count < issued_count) begin
			// Transaction still waiting for acceptance.
		end else if (query_q.size() != 0 && $urandom_range(99) >= query_q[0].gap_pct) begin
			start <= 1'b1;
			prime_index <= query_q[0].index;
			void'(query_q.pop_front());
			issued_count++;
		end else begin
			start <= 1'b0;
			prime_index <= INDEX_W'($urandom);
		end
	end

	// Monitor: check results in order, then record newly accepted queries.
	always @(posedge clk) begin : monitor
		prime_answer_t want;
		if (arst_n) begin
			if (done === 1'b1) begin
				if (answer_q.size() == 0) begin
					report_mismatch($sformatf("result %0d/%0b with no query pending",
						prime_value, not_found));
				end else begin
					want = answer_q.pop_front();
					answered_count++;
					if (want.missing) missing_count++;
					else found_count++;
					if (prime_value !== want.value)
						report_mismatch($sformatf("index %0d: prime_value %0d, expected %0d",
							want.index, prime_value, want.value));
					if (not_found !== want.missing)
						report_mismatch($sformatf("index %0d: not_found %0b, expected %0b",
							want.index, not_found, want.missing));
				end
			end
			if (start && busy === 1'b0) begin
				answer_q.push_back(predict_answer(prime_index));
				accepted_count++;
			end
		end
	end

	// Run limit, covering the clearing and sieving pass after reset.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > cycle_limit) begin
			$display("Timeout after %0d cycles with %0d results outstanding.",
				cycle_count, answer_q.size());
			$display("FAIL");
			$finish;
		end
	end

	// Stimulus, reset and end of run.
	initial begin : stimulus
		int pick;
		logic [INDEX_W-1:0] n;
		build_prime_table();
		cycle_limit = 4 * SIEVE_SIZE;

		// Directed part: index zero, the first primes, the edge of the map and
		// the all-ones index. The first query also arrives while still sieving.
		add_query(1, 0);
		add_query(0, 0);
		add_query(2, 0);
		add_query(3, 0);
		add_query(4, 0);
		add_query(5, 0);
		add_query(0, 0);
		add_query(10, 0);
		add_query(25, 0);
		add_query(100, 0);
		add_query(1000, 0);
		add_query(INDEX_W'(prime_table.size() - 1), 0);
		add_query(INDEX_W'(prime_table.size()), 0);
		add_query(INDEX_W'(prime_table.size() + 1), 0);
		add_query({INDEX_W{1'b1}}, 0);

		// Random part: mostly small indexes to keep scans short, with a few
		// near the end of the map, anywhere in the index range, or zero.
		for (int i = 0; i < RANDOM_QUERIES; i++) begin
			pick = $urandom_range(39);
			if (pick == 0) n = INDEX_W'($urandom);
			else if (pick == 1) n = INDEX_W'($urandom_range(prime_table.size() + 150,
				prime_table.size() - 150));
			else if (pick == 2) n = '0;
			else n = INDEX_W'($urandom_range(300, 1));
			add_query(n, GAP_PCT[i * 4 / RANDOM_QUERIES]);
		end
		cycle_limit = 4 * cycle_limit + 1000;

		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		while (query_q.size() != 0 || start || answer_q.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Covered %0d queries against %0d primes below %0d: %0d found, %0d not found.",
			answered_count, prime_table.size(), SIEVE_SIZE, found_count, missing_count);
		$display("Run took %0d cycles with %0d mismatches.", cycle_count, error_count);
		if (error_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/snp_pkg.sv
hw/rtl/snp_ram.sv
hw/rtl/snp_sieve.sv
hw/rtl/snp_scan.sv
hw/rtl/sieve_nth_prime_top.sv
dv/tb_top.sv
